// ----- src/assert_macros.svh -----
// Assertion macros for the RTL files; blst_ctrl includes them.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed: condition does not hold");
// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(lbl, trig, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("assertion failed: consequence one cycle later");
`else
`define ASSERT_ALWAYS(lbl, expr)
`define ASSERT_NEXT(lbl, trig, cond)
`endif
`endif

// ----- src/blst_pkg.sv -----
`timescale 1ns / 1ps

package blst_pkg;

	localparam int DEPTH       = 64;
	localparam int VALUE_WIDTH = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		CMD_PUSH  = 3'd0,
		CMD_POP   = 3'd1,
		CMD_TOP   = 3'd2,
		CMD_PRINT = 3'd3,
		CMD_EMPTY = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_POPPED   = 3'd0,
		KIND_TOP      = 3'd1,
		KIND_LISTED   = 3'd2,
		KIND_OVERFLOW = 3'd3,
		KIND_NODATA   = 3'd4,
		KIND_EMPTY    = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EMIT,
		S_READ
	} state_t;

	typedef struct packed {
		logic [2:0]          cmd;
		logic signed [31:0]  push_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          result_kind;
		logic signed [31:0]  result_value;
		logic                last_of_run;
	} out_item_t;

	// Sign-extend the 32-bit field, keep the stored width.
	function automatic logic [VALUE_WIDTH-1:0] store_value(input logic [31:0] pv);
		logic [63:0] w;
		w = 64'(signed'(pv));
		return w[VALUE_WIDTH-1:0];
	endfunction

	// Sign-extend a stored word, return the low 32 bits.
	function automatic logic [31:0] read_value(input logic [VALUE_WIDTH-1:0] raw);
		logic [63:0] w;
		w = 64'(signed'(raw));
		return w[31:0];
	endfunction

endpackage

// ----- src/blst_ram.sv -----
`timescale 1ns / 1ps

module blst_ram #(
	parameter int WIDTH   = 32,
	parameter int ENTRIES = 64
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(ENTRIES)-1:0] waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(ENTRIES)-1:0] raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Hold read data until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/blst_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module blst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  blst_pkg::in_item_t  req,
	input  logic                res_free,
	output logic                res_load,
	output blst_pkg::out_item_t res
);

	import blst_pkg::*;

	state_t                 state_q, state_d;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic [ADDR_W-1:0]      idx_q, idx_d;
	logic [ADDR_W-1:0]      end_q, end_d;
	kind_t                  kind_q, kind_d;
	out_item_t              pend_q, pend_d;

	logic                   ram_we;
	logic                   ram_re;
	logic [ADDR_W-1:0]      ram_raddr;
	logic [VALUE_WIDTH-1:0] ram_rdata;

	logic [CNT_W-1:0]       cnt_m1;
	logic [ADDR_W-1:0]      top_addr;
	logic                   is_empty;
	logic                   is_full;
	logic                   at_end;

	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign top_addr = cnt_m1[ADDR_W-1:0];
	assign is_empty = (cnt_q == '0);
	assign is_full  = (cnt_q == CNT_W'(DEPTH));
	assign at_end   = (idx_q == end_q);

	blst_ram #(
		.WIDTH   (VALUE_WIDTH),
		.ENTRIES (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[ADDR_W-1:0]),
		.wdata (store_value(req.push_value)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		end_q  <= end_d;
		kind_q <= kind_d;
		pend_q <= pend_d;
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		end_d     = end_q;
		kind_d    = kind_q;
		pend_d    = pend_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		res_load  = 1'b0;
		res       = pend_q;
		req_stall = (state_q != S_IDLE);

		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					case (req.cmd)
						CMD_PUSH: begin
							if (is_full) begin
								pend_d  = '{result_kind: KIND_OVERFLOW, result_value: '0,
									last_of_run: 1'b1};
								state_d = S_EMIT;
							end else begin
								ram_we = 1'b1;
								cnt_d  = cnt_q + CNT_W'(1);
							end
						end
						CMD_POP, CMD_TOP: begin
							if (!is_empty) begin
								ram_re    = 1'b1;
								ram_raddr = top_addr;
								idx_d     = top_addr;
								end_d     = top_addr;
								kind_d    = (req.cmd == CMD_POP) ? KIND_POPPED : KIND_TOP;
								if (req.cmd == CMD_POP) begin
									cnt_d = cnt_m1;
								end
								state_d   = S_READ;
							end else if (req.cmd == CMD_TOP) begin
								pend_d  = '{result_kind: KIND_NODATA, result_value: '0,
									last_of_run: 1'b1};
								state_d = S_EMIT;
							end
						end
						CMD_PRINT: begin
							if (!is_empty) begin
								ram_re    = 1'b1;
								ram_raddr = '0;
								idx_d     = '0;
								end_d     = top_addr;
								kind_d    = KIND_LISTED;
								state_d   = S_READ;
							end else begin
								pend_d  = '{result_kind: KIND_NODATA, result_value: '0,
									last_of_run: 1'b1};
								state_d = S_EMIT;
							end
						end
						CMD_EMPTY: begin
							pend_d  = '{result_kind: KIND_EMPTY,
								result_value: {31'd0, is_empty}, last_of_run: 1'b1};
							state_d = S_EMIT;
						end
						default: begin
						end
					endcase
				end
			end
			S_EMIT: begin
				res = pend_q;
				if (res_free) begin
					res_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			S_READ: begin
				res = '{result_kind: kind_q, result_value: read_value(ram_rdata),
					last_of_run: at_end};
				if (res_free) begin
					res_load = 1'b1;
					if (at_end) begin
						state_d = S_IDLE;
					end else begin
						// Fetch the next entry while this one leaves.
						idx_d     = idx_q + ADDR_W'(1);
						ram_re    = 1'b1;
						ram_raddr = idx_q + ADDR_W'(1);
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(DEPTH))
	`ASSERT_ALWAYS(a_no_rw_overlap, !ram_we || (state_q == S_IDLE && !ram_re))
	`ASSERT_NEXT(a_push_count,
		state_q == S_IDLE && req_valid && req.cmd == CMD_PUSH && !is_full,
		cnt_q == $past(cnt_q) + CNT_W'(1))
	`ASSERT_NEXT(a_last_returns_idle, res_load && res.last_of_run, state_q == S_IDLE)

endmodule

// ----- src/bounded_lifo_stack_top.sv -----
`timescale 1ns / 1ps
// Bounded LIFO stack of signed words, held in one synchronous RAM.
// Request channel (req_valid / req_stall / req) carries one command item:
// push, pop, top, print or empty. Response channel (rsp_valid / rsp_stall /
// rsp) carries result items; the final item of each command has last_of_run set.
// Push with room, pop on an empty stack and unknown codes give no item.
// A push with room completes as it is taken. For pop, top, empty and every error
// answer, the command is taken, then its item is registered and loaded into the
// response register once that register is free. Print reads the held entries
// from the bottom up, one per cycle while the receiver does not stall; the next
// read is issued as the current entry moves to the response register.
// One command is in work at a time; req_stall is high until the command's last
// item has been loaded. The response register lets the next command be taken
// while the last item still waits on a stalled receiver.
// When the receiver holds rsp_stall, the response item holds and the sequencer
// waits, holding the RAM read data, so nothing is lost.
// Reset clears the fill count and the sequencer; RAM contents are not cleared
// and no clearing pass is needed, since only entries below the fill count are
// read.

module bounded_lifo_stack_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  blst_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output blst_pkg::out_item_t rsp
);

	import blst_pkg::*;

	logic      res_free;
	logic      res_load;
	out_item_t res;
	logic      rsp_valid_q;
	out_item_t rsp_q;

	// Register is free when empty or when its item leaves this cycle.
	assign res_free = !rsp_valid_q || !rsp_stall;

	blst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_free  (res_free),
		.res_load  (res_load),
		.res       (res)
	);

	// Advance valid: set on load, drop once the receiver takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Hold the payload until a new item is loaded.
	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import blst_pkg::*;

	// Spare command codes: the block must ignore these.
	localparam logic [2:0] CMD_SPARE_A = 3'd5;
	localparam logic [2:0] CMD_SPARE_B = 3'd6;
	localparam logic [2:0] CMD_SPARE_C = 3'd7;

	localparam int ITEM_TARGET = 260;
	localparam int MAX_WAIT    = 11;
	// Items sent by the directed opening.
	localparam int DIRECTED_ITEMS = 23;

	// Shadow copy of the stack. It tracks the words and the fill level, and
	// queues the result items each accepted command must produce, in order.
	class stack_shadow;
		logic [VALUE_WIDTH-1:0] words[DEPTH];
		int unsigned            held;
		out_item_t              pending_results[$];
		int unsigned            fail_count;

		function new();
			held       = 0;
			fail_count = 0;
		endfunction

		// Sign-extend a stored word and keep the low 32 bits.
		function logic [31:0] widen(logic [VALUE_WIDTH-1:0] w);
			logic signed [VALUE_WIDTH-1:0] s;
			logic signed [63:0]            x;
			s = w;
			x = s;
			return x[31:0];
		endfunction

		function void add_result(kind_t k, logic [31:0] v, logic last);
			out_item_t r;
			r.result_kind  = k;
			r.result_value = v;
			r.last_of_run  = last;
			pending_results.push_back(r);
		endfunction

		// Apply one accepted command to the shadow and queue its results.
		function void note_command(in_item_t it);
			logic signed [31:0] pv;
			logic signed [63:0] wide;
			case (it.cmd)
			CMD_PUSH: begin
				if (held >= DEPTH) begin
					add_result(KIND_OVERFLOW, '0, 1'b1);
				end else begin
					pv          = it.push_value;
					wide        = pv;
					words[held] = wide[VALUE_WIDTH-1:0];
					held++;
				end
			end
			CMD_POP: begin
				if (held > 0) begin
					add_result(KIND_POPPED, widen(words[held-1]), 1'b1);
					held--;
				end
			end
			CMD_TOP: begin
				if (held == 0)
					add_result(KIND_NODATA, '0, 1'b1);
				else
					add_result(KIND_TOP, widen(words[held-1]), 1'b1);
			end
			CMD_PRINT: begin
				if (held == 0) begin
					add_result(KIND_NODATA, '0, 1'b1);
				end else begin
					for (int i = 0; i < held; i++)
						add_result(KIND_LISTED, widen(words[i]), i == held - 1);
				end
			end
			CMD_EMPTY: begin
				add_result(KIND_EMPTY, (held == 0) ? 32'd1 : 32'd0, 1'b1);
			end
			default: ;
			endcase
		endfunction

		// Compare one accepted result item against the oldest expectation.
		function void check_result(out_item_t got);
			out_item_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result item: result_kind %0d result_value %0d",
					got.result_kind, got.result_value);
				fail_count++;
				return;
			end
			want = pending_results.pop_front();
			if (got.result_kind !== want.result_kind) begin
				$error("result_kind: expected %0d, actual %0d",
					want.result_kind, got.result_kind);
				fail_count++;
			end
			if (got.result_value !== want.result_value) begin
				$error("result_value: expected %0d, actual %0d",
					want.result_value, got.result_value);
				fail_count++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0d, actual %0d",
					want.last_of_run, got.last_of_run);
				fail_count++;
			end
		endfunction
	endclass

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	in_item_t    req       = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	out_item_t   rsp;

	stack_shadow shadow    = new();
	// When set, the side runs back to back with no idle cycles.
	bit          req_calm  = 1'b0;
	bit          rsp_calm  = 1'b0;

	bounded_lifo_stack_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Hard stop, well beyond the slowest legal run (every print full, every
	// result stalled for the longest wait).
	initial begin
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	// Draw a push value, leaning on the extremes now and then.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 15))
		0:       return 32'h8000_0000;
		1:       return 32'h7FFF_FFFF;
		2:       return 32'h0000_0000;
		3:       return 32'hFFFF_FFFF;
		default: return $urandom();
		endcase
	endfunction

	// Present one command item and hold it until the block takes it.
	// Keep valid high across back-to-back items; drop it only when a gap is drawn.
	task automatic issue(input logic [2:0] code, input logic [31:0] value);
		in_item_t it;
		int       gap;
		it.cmd        = code;
		it.push_value = value;
		if ($urandom_range(0, 29) == 0)
			req_calm = !req_calm;
		gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		do @(posedge clk); while (req_stall);
		shadow.note_command(it);
	endtask

	// Response side: check every accepted result item, then stall for a drawn
	// number of cycles before taking the next one.
	initial begin
		int hold;
		hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				shadow.check_result(rsp);
				if ($urandom_range(0, 39) == 0)
					rsp_calm = !rsp_calm;
				hold = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				hold--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int counted;
		int burst;
		int pick;
		int op;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every command on an empty stack, extreme values, spare codes,
		// then drain past empty.
		issue(CMD_EMPTY, '0);
		issue(CMD_TOP,   '0);
		issue(CMD_PRINT, '0);
		issue(CMD_POP,   32'h1234_5678);
		issue(CMD_PUSH,  32'h8000_0000);
		issue(CMD_PUSH,  32'h7FFF_FFFF);
		issue(CMD_PUSH,  32'h0000_0000);
		issue(CMD_PUSH,  32'hFFFF_FFFF);
		issue(CMD_PUSH,  32'h0000_0001);
		issue(CMD_TOP,   32'hFFFF_FFFF);
		issue(CMD_PRINT, '0);
		issue(CMD_EMPTY, '0);
		issue(CMD_POP,   '0);
		issue(CMD_SPARE_A, 32'hAAAA_AAAA);
		issue(CMD_SPARE_B, 32'h5555_5555);
		issue(CMD_SPARE_C, 32'hFFFF_FFFF);
		issue(CMD_TOP,   '0);
		repeat (4) issue(CMD_POP, '0);
		issue(CMD_POP,   '0);
		issue(CMD_EMPTY, '0);

		// Random: push and pop runs that sweep the fill level from empty to full,
		// mixed with single commands of every kind, which are drawn most often. Open
		// with a full fill so overflow and a full-length print are always reached.
		counted = DIRECTED_ITEMS;
		pick    = 0;
		while (counted < ITEM_TARGET) begin
			if (pick < 1) begin
				// fill past the top, then list the full stack
				burst = DEPTH - shadow.held + $urandom_range(1, 3);
				repeat (burst) issue(CMD_PUSH, rand_word());
				issue(CMD_PRINT, $urandom());
				counted += burst + 1;
			end else if (pick < 4) begin
				// drain, sometimes past empty
				burst = $urandom_range(1, shadow.held + 2);
				repeat (burst) issue(CMD_POP, $urandom());
				counted += burst;
			end else if (pick < 8) begin
				burst = $urandom_range(1, 8);
				repeat (burst) issue(CMD_PUSH, rand_word());
				counted += burst;
			end else begin
				op = $urandom_range(0, 99);
				if (op < 30)
					issue(CMD_PUSH, rand_word());
				else if (op < 50)
					issue(CMD_POP, $urandom());
				else if (op < 62)
					issue(CMD_TOP, $urandom());
				else if (op < 72)
					issue(CMD_PRINT, $urandom());
				else if (op < 88)
					issue(CMD_EMPTY, $urandom());
				else
					issue(3'($urandom_range(CMD_SPARE_A, CMD_SPARE_C)), $urandom());
				counted++;
			end
			pick = $urandom_range(0, 19);
		end
		req_valid <= 1'b0;

		// Drain outstanding results, then let the block idle for a while to show any
		// stray item.
		while (shadow.pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (shadow.fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
